>>> src/btsm_pkg.sv
package btsm_pkg;

    // Field widths of one beat on each side.
    localparam int FUNC_W  = 3;
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 7;
    localparam int REG_W   = 6;
    localparam int WORD_W  = 64;
    localparam int WIN_W   = 32;

    // Operation codes carried in the input tuser field.
    localparam logic [FUNC_W-1:0] FUNC_CHECK_RANGE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAINT_RANGE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_RANGE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CHECK_REG   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TAINT_REG   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_REG   = 3'd5;

    // One result beat.
    typedef struct packed {
        logic out_of_window;
        logic tainted;
    } t_result;

endpackage

>>> src/btsm_shadow_ram.sv
module btsm_shadow_ram #(
    parameter int AW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [btsm_pkg::WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [btsm_pkg::WORD_W-1:0] o_rdata
);
    import btsm_pkg::*;

    logic [WORD_W-1:0] r_mem [1<<AW];
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_byp_data;
    logic              r_byp;

    // Bitmap storage, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // A read of the entry written in the same cycle returns the new word.
    always_ff @(posedge i_clk) begin
        r_byp      <= i_we && (i_waddr == i_raddr);
        r_byp_data <= i_wdata;
    end

    assign o_rdata = r_byp ? r_byp_data : r_rdata;

endmodule

>>> src/btsm_result_fifo.sv
module btsm_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  btsm_pkg::t_result i_data,
    output logic              o_valid,
    output btsm_pkg::t_result o_data,
    input  logic              i_ready
);
    import btsm_pkg::*;

    t_result    r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rptr];

    // Two-entry result buffer so a finished result never stalls the datapath.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

endmodule

>>> src/byte_taint_shadow_map_unit.sv
// Taint tracker with one bit per byte of a 2^WINDOW_BITS byte window and one bit
// per general register. Each input beat checks, taints or clears a byte range of
// up to MAX_RANGE bytes, or one register; one result beat follows each input beat.
// The byte bitmap lives in a single 64-bit wide memory with one read and one write
// port; a range touches at most two words, which are read, modified and written
// back one after the other (S_W0, S_W1); a new beat is taken in S_W1 while fewer
// than two results are owed. After reset the block clears all 2^(WINDOW_BITS-6)
// bitmap words (1024 by default) one word a cycle, and holds s_axis_tready low
// meanwhile. Bytes outside the window that the window register selects check clean,
// are not written, and set out_of_window. A new window leaves the bitmap as it is.
module byte_taint_shadow_map_unit #(
    parameter int WINDOW_BITS = 16,
    parameter int MAX_RANGE   = 64,
    parameter int NUM_REGS    = 19
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input beats.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [47:0] address, [54:48] length, [60:55] reg_index, [63:61] zero
    input  logic [63:0] s_axis_tdata,
    // [2:0] func
    input  logic [2:0]  s_axis_tuser,
    // Result beats.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] tainted, [1] out_of_window, [7:2] zero
    output logic [7:0]  m_axis_tdata,
    // Window register write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import btsm_pkg::*;

    localparam int AW = WINDOW_BITS - 6;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_W0    = 4'b0100,
        S_W1    = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [WIN_W-1:0]    r_win;
    logic [AW-1:0]       r_clr_idx;
    logic [1:0]          r_pend;
    logic [NUM_REGS-1:0] r_regs, n_regs;

    logic [FUNC_W-1:0]   r_func;
    logic [WORD_W-1:0]   r_mask0, r_mask1;
    logic                r_in0, r_in1;
    logic [AW-1:0]       r_idx1;
    logic                r_oow;
    logic [NUM_REGS-1:0] r_reg_sel;
    logic                r_hit, n_hit;

    logic                in_fire, out_fire;
    logic [FUNC_W-1:0]   in_func;
    logic [ADDR_W-1:0]   in_addr;
    logic [LEN_W-1:0]    in_len, len_sat;
    logic [REG_W-1:0]    in_reg;
    logic [127:0]        span;
    logic                is_range;
    logic [WORD_W-1:0]   mask0, mask1;
    logic [41:0]         wa0, wa1;
    logic                in0, in1;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [WORD_W-1:0]   mem_wdata, mem_rdata;

    logic [WORD_W-1:0]   cur_mask;
    logic                cur_in;
    logic                word_hit;
    logic                is_update;
    logic                res_push;
    t_result             res_data, out_data;

    function automatic logic win_hit(input logic [41:0] wa, input logic [WIN_W-1:0] win);
        return 64'(wa[41:AW]) == 64'(win);
    endfunction

    // Field unpacking of the input beat.
    assign in_func = s_axis_tuser;
    assign in_addr = s_axis_tdata[47:0];
    assign in_len  = s_axis_tdata[54:48];
    assign in_reg  = s_axis_tdata[60:55];

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Byte masks of the two bitmap words a range can touch.
    assign len_sat  = (in_len > LEN_W'(MAX_RANGE)) ? LEN_W'(MAX_RANGE) : in_len;
    assign span     = ((128'd1 << len_sat) - 128'd1) << in_addr[5:0];
    assign is_range = (in_func <= FUNC_CLEAR_RANGE);
    assign mask0    = is_range ? span[63:0] : '0;
    assign mask1    = is_range ? span[127:64] : '0;
    assign wa0      = in_addr[47:6];
    assign wa1      = wa0 + 42'd1;
    assign in0      = win_hit(wa0, r_win);
    assign in1      = win_hit(wa1, r_win);

    // Window register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_cfg_valid) begin
            r_win <= i_cfg_data;
        end
    end

    // New beats are taken in S_IDLE or S_W1 while fewer than two results are owed.
    assign s_axis_tready = ((r_state == S_IDLE) || (r_state == S_W1)) && (r_pend != 2'd2);

    // Item capture at acceptance.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func    <= in_func;
            r_mask0   <= mask0;
            r_mask1   <= mask1;
            r_in0     <= in0;
            r_in1     <= in1;
            r_idx1    <= wa1[AW-1:0];
            r_oow     <= ((|mask0) && !in0) || ((|mask1) && !in1);
            r_reg_sel <= NUM_REGS'(1) << in_reg;
        end
    end

    // Word under work: the first word in S_W0, the second in S_W1.
    assign cur_mask  = (r_state == S_W1) ? r_mask1 : r_mask0;
    assign cur_in    = (r_state == S_W1) ? r_in1 : r_in0;
    assign word_hit  = cur_in && (r_func == FUNC_CHECK_RANGE) && (|(mem_rdata & cur_mask));
    assign is_update = (r_func == FUNC_TAINT_RANGE) || (r_func == FUNC_CLEAR_RANGE);

    // Memory port control: clearing sweep, or write-back of the word under work.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_idx;
        mem_wdata = '0;
        mem_raddr = (r_state == S_W0) ? r_idx1 : wa0[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_W0: begin
                mem_we    = r_in0 && (|r_mask0) && is_update;
                mem_waddr = mem_raddr - AW'(1);
            end
            S_W1: begin
                mem_we    = r_in1 && (|r_mask1) && is_update;
                mem_waddr = r_idx1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        // The clearing sweep writes zeros; otherwise the word is updated in place.
        if (r_state != S_CLEAR) begin
            mem_wdata = (r_func == FUNC_TAINT_RANGE) ? (mem_rdata | cur_mask)
                                                     : (mem_rdata & ~cur_mask);
        end
    end

    // Register taint bits and the running check result.
    always_comb begin
        n_regs = r_regs;
        n_hit  = r_hit;
        if (r_state == S_W0) begin
            n_hit = word_hit
                 || ((r_func == FUNC_CHECK_REG) && (|(r_regs & r_reg_sel)));
            if (r_func == FUNC_TAINT_REG) begin
                n_regs = r_regs | r_reg_sel;
            end else if (r_func == FUNC_CLEAR_REG) begin
                n_regs = r_regs & ~r_reg_sel;
            end
        end
    end

    assign res_push               = (r_state == S_W1);
    assign res_data.tainted       = r_hit || word_hit;
    assign res_data.out_of_window = r_oow;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == {AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_W0;
                end
            end
            S_W0: begin
                n_state = S_W1;
            end
            S_W1: begin
                n_state = in_fire ? S_W0 : S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_pend    <= 2'd0;
            r_regs    <= '0;
        end else begin
            r_state <= n_state;
            r_regs  <= n_regs;
            r_pend  <= r_pend + 2'(in_fire) - 2'(out_fire);
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
        end
    end

    btsm_shadow_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    btsm_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_valid (m_axis_tvalid),
        .o_data  (out_data),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, out_data.out_of_window, out_data.tainted};

endmodule

>>> src/btsm_checker.sv
module btsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [31:0] i_cfg_data
);

    // A held result beat keeps its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // Each accepted item moves the sequencer to S_W0, where no input beat is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input beat taken in the cycle after another");

    // Reset empties the result buffer.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Reset starts the clearing sweep, so no beat is taken.
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // Padding bits of the result are zero.
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'd0))
        else $error("result padding bits set");

endmodule

bind byte_taint_shadow_map_unit btsm_checker u_btsm_checker (.*);

>>> tb/sv/byte_taint_shadow_map_unit_tb.sv
module byte_taint_shadow_map_unit_tb;

    import btsm_pkg::*;

    localparam int WINDOW_BITS = 16;
    localparam int MAX_RANGE   = 64;
    localparam int NUM_REGS    = 19;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 100;

    // Function codes that the block must treat as no-ops.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [REG_W-1:0]  reg_idx;
    } t_taint_op;

    typedef struct {
        t_taint_op op;
        bit        typed;
        t_result   want;
    } t_directed_row;

    // Receiver stall patterns.
    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_TRICKLE} t_rx_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata = '0;
    logic [2:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [WIN_W-1:0]  i_cfg_data = '0;

    // Shadow copy of the block state.
    bit                shadow_bits [0:(1 << WINDOW_BITS) - 1];
    bit [63:0]         reg_taint;
    logic [WIN_W-1:0]  window_reg;

    t_result           taint_results_due [$];
    t_directed_row     directed_rows [$];
    int                error_count = 0;
    int                result_count = 0;
    int                cycle_count = 0;
    int                burst_left = 0;
    t_rx_mode          rx_mode = RX_OPEN;
    int                rx_span = 0;
    int                rx_tick = 0;

    byte_taint_shadow_map_unit #(
        .WINDOW_BITS(WINDOW_BITS),
        .MAX_RANGE  (MAX_RANGE),
        .NUM_REGS   (NUM_REGS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the shadow state and return the result it should give.
    function automatic t_result apply_taint_op(t_taint_op op);
        t_result           res;
        int                count;
        logic [ADDR_W-1:0] a;
        res = '0;
        count = (op.len > MAX_RANGE) ? MAX_RANGE : int'(op.len);
        if (op.func <= FUNC_CLEAR_RANGE) begin
            for (int i = 0; i < count; i++) begin
                a = op.addr + ADDR_W'(i);
                if (a[ADDR_W-1:WINDOW_BITS] != window_reg) begin
                    res.out_of_window = 1'b1;
                end else if (op.func == FUNC_CHECK_RANGE) begin
                    if (shadow_bits[a[WINDOW_BITS-1:0]]) res.tainted = 1'b1;
                end else if (op.func == FUNC_TAINT_RANGE) begin
                    shadow_bits[a[WINDOW_BITS-1:0]] = 1'b1;
                end else begin
                    shadow_bits[a[WINDOW_BITS-1:0]] = 1'b0;
                end
            end
        end else if (op.func <= FUNC_CLEAR_REG && op.reg_idx < NUM_REGS) begin
            if (op.func == FUNC_CHECK_REG) res.tainted = reg_taint[op.reg_idx];
            else if (op.func == FUNC_TAINT_REG) reg_taint[op.reg_idx] = 1'b1;
            else reg_taint[op.reg_idx] = 1'b0;
        end
        return res;
    endfunction

    // Random operation, aimed mostly at a small hot region and the window edges.
    function automatic t_taint_op random_taint_op();
        t_taint_op op;
        int        sel;
        int        pick;
        sel = $urandom_range(0, 99);
        if (sel < 45) op.addr = {window_reg, 16'($urandom_range(0, 767))};
        else if (sel < 60) op.addr = {window_reg, 16'hFFFF - 16'($urandom_range(0, 100))};
        else if (sel < 70) op.addr = {window_reg - 1'b1, 16'hFFFF - 16'($urandom_range(0, 80))};
        else if (sel < 85) op.addr = {window_reg, 16'($urandom())};
        else op.addr = {16'($urandom()), 32'($urandom())};

        sel = $urandom_range(0, 99);
        if (sel < 5) op.len = '0;
        else if (sel < 15) op.len = LEN_W'($urandom_range(65, 127));
        else op.len = LEN_W'($urandom_range(1, 64));

        op.reg_idx = ($urandom_range(0, 4) != 0) ? REG_W'($urandom_range(0, NUM_REGS - 1))
                                                 : REG_W'($urandom_range(0, 63));

        pick = $urandom_range(0, 99);
        if (pick < 30) op.func = FUNC_CHECK_RANGE;
        else if (pick < 55) op.func = FUNC_TAINT_RANGE;
        else if (pick < 70) op.func = FUNC_CLEAR_RANGE;
        else if (pick < 80) op.func = FUNC_CHECK_REG;
        else if (pick < 88) op.func = FUNC_TAINT_REG;
        else if (pick < 95) op.func = FUNC_CLEAR_REG;
        else if (pick < 97) op.func = FUNC_SPARE_6;
        else op.func = FUNC_SPARE_7;
        return op;
    endfunction

    function automatic void add_row(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr,
                                    logic [LEN_W-1:0] len, logic [REG_W-1:0] reg_idx,
                                    bit typed, logic tainted, logic oow);
        t_directed_row row;
        row.op.func = func;
        row.op.addr = addr;
        row.op.len = len;
        row.op.reg_idx = reg_idx;
        row.typed = typed;
        row.want.tainted = tainted;
        row.want.out_of_window = oow;
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string field, logic want, logic got);
        $display("mismatch on result %0d: %s expected %b, got %b",
                 result_count, field, want, got);
        error_count++;
    endtask

    // Send one beat in bursts with random gaps; called and returning at a rising edge.
    task automatic send_op(t_taint_op op, bit typed, t_result want);
        int      gap;
        t_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, op.reg_idx, op.len, op.addr};
        s_axis_tuser <= op.func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        res = apply_taint_op(op);
        taint_results_due.push_back(typed ? want : res);
    endtask

    // Drain the block, then write the window register.
    task automatic write_window(logic [WIN_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (taint_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        window_reg = value;
    endtask

    // Receiver: switch between stall patterns every so often.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_span == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_span <= $urandom_range(50, 150);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_EVERY4: m_axis_tready <= (rx_tick % 4 == 0);
            default:   m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[1:0]);
            if (taint_results_due.size() == 0) begin
                $display("unexpected result %0d: tainted %b, out_of_window %b",
                         result_count, got.tainted, got.out_of_window);
                error_count++;
            end else begin
                want = taint_results_due.pop_front();
                if (got.tainted !== want.tainted)
                    report_mismatch("tainted", want.tainted, got.tainted);
                if (got.out_of_window !== want.out_of_window)
                    report_mismatch("out_of_window", want.out_of_window, got.out_of_window);
            end
            result_count++;
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("[byte_taint_shadow_map_unit] ERROR");
        $finish;
    end

    initial begin
        logic [WIN_W-1:0] windows [6];
        t_result          none;
        none = '0;
        reg_taint = '0;
        window_reg = '0;
        foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;

        // Directed rows; typed results are the ones obvious from the state.
        add_row(FUNC_CHECK_RANGE, 48'h0, 7'd64, 6'd0, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_TAINT_RANGE, 48'h0, 7'd1, 6'd0, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_CHECK_RANGE, 48'h0, 7'd1, 6'd0, 1'b1, 1'b1, 1'b0);
        add_row(FUNC_CHECK_RANGE, 48'h0, 7'd0, 6'd0, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_TAINT_RANGE, 48'hFFC0, 7'd64, 6'd0, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_CHECK_RANGE, 48'hFFFF, 7'd2, 6'd0, 1'b1, 1'b1, 1'b1);
        // Saturated length running off the top of the address space.
        add_row(FUNC_TAINT_RANGE, 48'hFFFF_FFFF_FFF0, 7'd127, 6'd0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_CHECK_RANGE, 48'h30, 7'd16, 6'd0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_CHECK_RANGE, 48'h2F, 7'd1, 6'd0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_CLEAR_RANGE, 48'h0, 7'd100, 6'd0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_CHECK_RANGE, 48'h0, 7'd127, 6'd0, 1'b0, 1'b0, 1'b0);
        add_row(FUNC_CHECK_RANGE, 48'h8000_0000_0000, 7'd64, 6'd0, 1'b1, 1'b0, 1'b1);
        add_row(FUNC_CHECK_RANGE, 48'hFFFF_FFFF_FFFF, 7'd1, 6'd0, 1'b1, 1'b0, 1'b1);
        add_row(FUNC_CHECK_REG, 48'h8000_0000_0000, 7'd64, 6'd0, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_TAINT_REG, 48'h0, 7'd0, 6'd0, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_TAINT_REG, 48'h0, 7'd0, 6'd18, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_TAINT_REG, 48'h0, 7'd0, 6'd19, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_TAINT_REG, 48'h0, 7'd0, 6'd63, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_CHECK_REG, 48'h0, 7'd0, 6'd0, 1'b1, 1'b1, 1'b0);
        add_row(FUNC_CHECK_REG, 48'h0, 7'd0, 6'd18, 1'b1, 1'b1, 1'b0);
        add_row(FUNC_CHECK_REG, 48'h0, 7'd0, 6'd19, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_CHECK_REG, 48'h0, 7'd0, 6'd63, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_CLEAR_REG, 48'h0, 7'd0, 6'd18, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_CHECK_REG, 48'h0, 7'd0, 6'd18, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_SPARE_6, 48'hFFFF_FFFF_FFFF, 7'd64, 6'd0, 1'b1, 1'b0, 1'b0);
        add_row(FUNC_SPARE_7, 48'h0, 7'd64, 6'd0, 1'b1, 1'b0, 1'b0);

        // Window settings for the random phases; the bitmap carries across them.
        windows[0] = 32'hFFFF_FFFF;
        windows[1] = 32'h0000_0001;
        windows[2] = 32'($urandom());
        windows[3] = 32'h0000_0000;
        windows[4] = 32'($urandom());
        windows[5] = 32'h8000_0000;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_window(32'h0);
        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);

        foreach (windows[p]) begin
            write_window(windows[p]);
            repeat (PHASE_ITEMS) send_op(random_taint_op(), 1'b0, none);
        end

        // Drain and let any stray beat show up.
        s_axis_tvalid <= 1'b0;
        while (taint_results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0 && taint_results_due.size() == 0) begin
            $display("[byte_taint_shadow_map_unit] OK");
        end else begin
            $display("[byte_taint_shadow_map_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
src/btsm_pkg.sv
src/btsm_shadow_ram.sv
src/btsm_result_fifo.sv
src/byte_taint_shadow_map_unit.sv
src/btsm_checker.sv
tb/sv/byte_taint_shadow_map_unit_tb.sv
